// File: hw/rtl/mh64_pkg.sv
// ----------------------------------------------------------------------------
// mh64_pkg
// Shared constants and types for the MurmurHash64A stream hasher.
// ----------------------------------------------------------------------------
package mh64_pkg;

  localparam int unsigned HASH_W    = 64;
  localparam int unsigned HALF_W    = HASH_W / 2;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned MIX_SHIFT = 47;

  localparam logic [HASH_W-1:0] MIX_MUL    = 64'hc6a4_a793_5bd1_e995;
  localparam logic [HASH_W-1:0] SEED_RESET = 64'd42;
  localparam logic [CNT_W-1:0]  FULL_CNT   = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPEN,
    S_MIX1,
    S_MIX2,
    S_MIX3,
    S_TAIL,
    S_FIN,
    S_DONE
  } state_t;

endpackage

// File: hw/rtl/mh64_mul.sv
// ----------------------------------------------------------------------------
// mh64_mul
// Shared multiplier: operand * MIX_MUL mod 2^64 from three 32x32 partial
// products, one per cycle, summed into an accumulator.
// ----------------------------------------------------------------------------
module mh64_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mh64_pkg::HASH_W-1:0]  operand,
  output logic                         done,
  output logic [mh64_pkg::HASH_W-1:0]  product
);
  import mh64_pkg::*;

  logic [HASH_W-1:0] a;
  logic [HASH_W-1:0] prod;
  logic [HASH_W-1:0] acc;
  logic [1:0]        step;
  logic              active;
  logic [HALF_W-1:0] a_sel;
  logic [HALF_W-1:0] m_sel;
  logic [HASH_W-1:0] mul_out;

  always_comb begin
    case (step)
      2'd0: begin
        a_sel = a[HALF_W-1:0];
        m_sel = MIX_MUL[HALF_W-1:0];
      end
      2'd1: begin
        a_sel = a[HALF_W-1:0];
        m_sel = MIX_MUL[HASH_W-1:HALF_W];
      end
      default: begin
        a_sel = a[HASH_W-1:HALF_W];
        m_sel = MIX_MUL[HALF_W-1:0];
      end
    endcase
  end

  assign mul_out = {{HALF_W{1'b0}}, a_sel} * {{HALF_W{1'b0}}, m_sel};
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= 2'd0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= 2'd0;
      end else if (active) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // low x low, then the two cross terms into the upper half
  always_ff @(posedge clk) begin
    if (start) begin
      a <= operand;
    end else if (active) begin
      prod <= mul_out;
      case (step)
        2'd0:    acc <= acc;
        2'd1:    acc <= prod;
        default: acc[HASH_W-1:HALF_W] <= acc[HASH_W-1:HALF_W] + prod[HALF_W-1:0];
      endcase
    end
  end

endmodule

// File: hw/rtl/murmur64a_stream_hash.sv
// ----------------------------------------------------------------------------
// murmur64a_stream_hash
// MurmurHash64A over a byte string delivered as 8-byte little-endian words.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one word per message block, first byte
// in bits 7:0. message_length is taken from the first word of a message.
// A word with byte_count below 8, or with last_block set, ends the message;
// an empty message is a single word with byte_count 0.
// Output channel (out_valid/out_ready): one hash per message, held in an
// output register.
// cfg_wr_en/cfg_wr_data load the seed (42 after reset); write it between
// messages.
// All 64-bit multiplies by the mixing constant go through one shared 32x32
// multiplier. A word takes one to five multiplies: opening a message costs
// one, a full block three, a tail one, finalizing one. in_ready is high only
// while idle.
// A finished hash waits in the output register; the next message can be
// worked on meanwhile, but its own result stalls until the register frees.
// Reset (rst, synchronous) closes any open message and clears out_valid.
// ----------------------------------------------------------------------------
module murmur64a_stream_hash (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [mh64_pkg::HASH_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mh64_pkg::HASH_W-1:0]  block_data,
  input  logic [mh64_pkg::CNT_W-1:0]   byte_count,
  input  logic [mh64_pkg::LEN_W-1:0]   message_length,
  input  logic                         last_block,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mh64_pkg::HASH_W-1:0]  hash_value
);
  import mh64_pkg::*;

  state_t            state, state_next;
  logic              issued, issued_next;
  logic              open_msg, open_msg_next;
  logic              out_valid_next;
  logic [HASH_W-1:0] seed;
  logic [HASH_W-1:0] h, h_next;
  logic [HASH_W-1:0] k, k_next;
  logic [HASH_W-1:0] dat;
  logic [LEN_W-1:0]  len;
  logic [CNT_W-1:0]  cnt;
  logic              lst;
  logic [HASH_W-1:0] hash_next;

  logic              mul_start;
  logic              mul_done;
  logic [HASH_W-1:0] mul_operand;
  logic [HASH_W-1:0] mul_product;

  logic              accept;
  logic [CNT_W-1:0]  cnt_sat;
  logic [HASH_W-1:0] tail_mask;
  logic              compute;
  state_t            body_state;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign cnt_sat  = (byte_count > FULL_CNT) ? FULL_CNT : byte_count;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      tail_mask[8*i +: 8] = (CNT_W'(i) < cnt) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    if (cnt == FULL_CNT) begin
      body_state = S_MIX1;
    end else if (cnt != '0) begin
      body_state = S_TAIL;
    end else begin
      body_state = S_FIN;
    end
  end

  always_comb begin
    case (state)
      S_OPEN:  mul_operand = {{(HASH_W-LEN_W){1'b0}}, len};
      S_MIX1:  mul_operand = dat;
      S_MIX2:  mul_operand = k ^ (k >> MIX_SHIFT);
      S_MIX3:  mul_operand = h ^ k;
      S_TAIL:  mul_operand = h ^ (dat & tail_mask);
      S_FIN:   mul_operand = h ^ (h >> MIX_SHIFT);
      default: mul_operand = '0;
    endcase
  end

  assign compute = (state == S_OPEN) || (state == S_MIX1) || (state == S_MIX2) ||
                   (state == S_MIX3) || (state == S_TAIL) || (state == S_FIN);
  assign mul_start = compute && !issued;

  mh64_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .operand (mul_operand),
    .done    (mul_done),
    .product (mul_product)
  );

  always_comb begin
    state_next     = state;
    issued_next    = issued;
    open_msg_next  = open_msg;
    h_next         = h;
    k_next         = k;
    hash_next      = hash_value;
    out_valid_next = out_valid && !out_ready;

    if (mul_start) begin
      issued_next = 1'b1;
    end
    if (mul_done) begin
      issued_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          open_msg_next = 1'b1;
          if (!open_msg) begin
            state_next = S_OPEN;
          end else if (cnt_sat == FULL_CNT) begin
            state_next = S_MIX1;
          end else if (cnt_sat != '0) begin
            state_next = S_TAIL;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_OPEN: begin
        if (mul_done) begin
          h_next     = seed ^ mul_product;
          state_next = body_state;
        end
      end
      S_MIX1: begin
        if (mul_done) begin
          k_next     = mul_product;
          state_next = S_MIX2;
        end
      end
      S_MIX2: begin
        if (mul_done) begin
          k_next     = mul_product;
          state_next = S_MIX3;
        end
      end
      S_MIX3: begin
        if (mul_done) begin
          h_next     = mul_product;
          state_next = lst ? S_FIN : S_IDLE;
        end
      end
      S_TAIL: begin
        if (mul_done) begin
          h_next     = mul_product;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (mul_done) begin
          k_next     = mul_product;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          hash_next      = k ^ (k >> MIX_SHIFT);
          out_valid_next = 1'b1;
          h_next         = '0;
          open_msg_next  = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      open_msg  <= 1'b0;
      out_valid <= 1'b0;
      seed      <= SEED_RESET;
      h         <= '0;
    end else begin
      state     <= state_next;
      issued    <= issued_next;
      open_msg  <= open_msg_next;
      out_valid <= out_valid_next;
      h         <= h_next;
      if (cfg_wr_en) begin
        seed <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    k          <= k_next;
    hash_value <= hash_next;
    if (accept) begin
      dat <= block_data;
      len <= message_length;
      cnt <= cnt_sat;
      lst <= last_block || (cnt_sat != FULL_CNT);
    end
  end

endmodule

// File: hw/rtl/mh64_checker.sv
// ----------------------------------------------------------------------------
// mh64_checker
// Port-level checks for murmur64a_stream_hash, bound to the top level.
// ----------------------------------------------------------------------------
module mh64_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mh64_pkg::HASH_W-1:0]  hash_value
);
  import mh64_pkg::*;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash_value))
    else $error("output word changed while stalled");

  // one word at a time: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // a new result only comes out of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("reset did not clear the channels");

endmodule

bind murmur64a_stream_hash mh64_checker u_mh64_checker (.*);
